### rtl/calendar_clock_with_dst_unit_assert.svh
// Assertion macros for the calendar clock unit.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CALENDAR_CLOCK_WITH_DST_UNIT_ASSERT_SVH
`define CALENDAR_CLOCK_WITH_DST_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define CCDST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define CCDST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ccdst_pkg.sv
package ccdst_pkg;

  // Item opcodes
  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } opcode_t;

  // Field limits
  localparam logic [4:0]  HOUR_MAX     = 5'd23;
  localparam logic [5:0]  MINSEC_MAX   = 6'd59;
  localparam logic [4:0]  DAY_MIN      = 5'd1;
  localparam logic [3:0]  MONTH_MIN    = 4'd1;
  localparam logic [3:0]  MONTH_MAX    = 4'd12;
  localparam logic [13:0] YEAR_MIN     = 14'd1;
  localparam logic [13:0] YEAR_MAX     = 14'd9999;
  localparam logic [2:0]  WEEKDAY_MAX  = 3'd6;

  // Month numbers, January is 1
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_MAR = 4'd3;
  localparam logic [3:0]  MONTH_APR = 4'd4;
  localparam logic [3:0]  MONTH_JUN = 4'd6;
  localparam logic [3:0]  MONTH_SEP = 4'd9;
  localparam logic [3:0]  MONTH_OCT = 4'd10;
  localparam logic [3:0]  MONTH_NOV = 4'd11;
  localparam logic [3:0]  MONTH_DEC = 4'd12;

  // Daylight-saving switch points
  localparam logic [2:0]  SUNDAY         = 3'd6;
  localparam logic [4:0]  LAST_WEEK_DAY  = 5'd25;
  localparam logic [4:0]  HOUR_SPRING    = 5'd2;
  localparam logic [4:0]  HOUR_FALL      = 5'd3;

  // Reset values
  localparam logic [13:0] YEAR_RESET    = 14'd2019;
  localparam logic [2:0]  WEEKDAY_RESET = 3'd1;

  // Inverse of 25 modulo 2**14, and the largest product of a multiple of 25
  localparam logic [13:0] INV25_MOD     = 14'd7209;
  localparam logic [13:0] DIV25_LIMIT   = 14'd655;

  // Clock and calendar state, kept in display form
  typedef struct packed {
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
    logic        fb_armed;
  } clk_state_t;

  // One input word
  typedef struct packed {
    opcode_t     opcode;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
  } item_t;

  // Saturate a loaded calendar state into range (the day only at its lower bound)
  function automatic clk_state_t sat_load(input item_t it);
    clk_state_t s;
    s.hours    = (it.hours > HOUR_MAX) ? HOUR_MAX : it.hours;
    s.minutes  = (it.minutes > MINSEC_MAX) ? MINSEC_MAX : it.minutes;
    s.seconds  = (it.seconds > MINSEC_MAX) ? MINSEC_MAX : it.seconds;
    s.day      = (it.day < DAY_MIN) ? DAY_MIN : it.day;
    s.month    = (it.month < MONTH_MIN) ? MONTH_MIN :
                 (it.month > MONTH_MAX) ? MONTH_MAX : it.month;
    s.year     = (it.year < YEAR_MIN) ? YEAR_MIN :
                 (it.year > YEAR_MAX) ? YEAR_MAX : it.year;
    s.weekday  = (it.weekday > WEEKDAY_MAX) ? WEEKDAY_MAX : it.weekday;
    s.fb_armed = 1'b1;
    return s;
  endfunction

endpackage

### rtl/ccdst_step.sv
module ccdst_step
  import ccdst_pkg::*;
(
  input  clk_state_t cur,
  input  item_t      item,
  output clk_state_t nxt,
  output logic       new_day
);

  logic [13:0] inv_prod;
  logic        div4;
  logic        div16;
  logic        div25;
  logic        leap;
  logic [4:0]  last_day;
  clk_state_t  upd;
  logic        last_sunday;
  logic        on_hour;

  // Gregorian leap test: divisible by 100 means by 4 and 25, by 400 adds 16
  assign inv_prod = cur.year * INV25_MOD;
  assign div4     = (cur.year[1:0] == 2'd0);
  assign div16    = (cur.year[3:0] == 4'd0);
  assign div25    = (inv_prod <= DIV25_LIMIT);
  assign leap     = div4 && (!div25 || div16);

  // Pick the month length
  always_comb begin
    unique case (cur.month)
      MONTH_FEB: last_day = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: last_day = 5'd30;
      default: last_day = 5'd31;
    endcase
  end

  // Load or advance one second, then roll the date at midnight
  always_comb begin
    upd     = cur;
    new_day = 1'b0;
    if (item.opcode == OP_LOAD) begin
      upd = sat_load(item);
    end else if (cur.seconds < MINSEC_MAX) begin
      upd.seconds = cur.seconds + 6'd1;
    end else begin
      upd.seconds = '0;
      if (cur.minutes < MINSEC_MAX) begin
        upd.minutes = cur.minutes + 6'd1;
      end else begin
        upd.minutes = '0;
        if (cur.hours < HOUR_MAX) begin
          upd.hours = cur.hours + 5'd1;
        end else begin
          upd.hours    = '0;
          new_day      = 1'b1;
          upd.fb_armed = 1'b1;
          upd.weekday  = (cur.weekday >= WEEKDAY_MAX) ? 3'd0 : cur.weekday + 3'd1;
          if (cur.day >= last_day) begin
            upd.day = DAY_MIN;
            if (cur.month >= MONTH_DEC) begin
              upd.month = MONTH_MIN;
              upd.year  = (cur.year >= YEAR_MAX) ? YEAR_MIN : cur.year + 14'd1;
            end else begin
              upd.month = cur.month + 4'd1;
            end
          end else begin
            upd.day = cur.day + 5'd1;
          end
        end
      end
    end
  end

  // Apply the daylight-saving jumps on the last Sunday of March and October
  assign last_sunday = (upd.weekday == SUNDAY) && (upd.day >= LAST_WEEK_DAY);
  assign on_hour     = (upd.minutes == 6'd0) && (upd.seconds == 6'd0);

  always_comb begin
    nxt = upd;
    if (last_sunday && on_hour) begin
      if (upd.month == MONTH_MAR && upd.hours == HOUR_SPRING) begin
        nxt.hours = HOUR_FALL;
      end else if (upd.month == MONTH_OCT && upd.hours == HOUR_FALL && upd.fb_armed) begin
        nxt.hours    = HOUR_SPRING;
        nxt.fb_armed = 1'b0;
      end
    end
  end

endmodule

### rtl/calendar_clock_with_dst_unit.sv
// Calendar clock with daylight-saving switches.
// A word is captured in the input register, stepped, and registered in the output register.
// Throughput: one word per cycle; the input register and the output register
// each hold a word, so the input stalls only while a full output is stalled.
// Reset (rst_n low, synchronous): both registers empty, time 00:00:00,
// 1 January 2019, Tuesday, fall-back guard armed.
`include "calendar_clock_with_dst_unit_assert.svh"

module calendar_clock_with_dst_unit
  import ccdst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [4:0]  in_load_hours,
  input  logic [5:0]  in_load_minutes,
  input  logic [5:0]  in_load_seconds,
  input  logic [4:0]  in_load_day,
  input  logic [3:0]  in_load_month,
  input  logic [13:0] in_load_year,
  input  logic [2:0]  in_load_weekday,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_hours,
  output logic [5:0]  out_minutes,
  output logic [5:0]  out_seconds,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [13:0] out_year,
  output logic [2:0]  out_weekday,
  output logic        out_new_day
);

  logic       in_vld_r;
  item_t      in_item_r;
  clk_state_t st_r;
  clk_state_t st_nxt;
  logic       new_day_nxt;
  logic       out_vld_r;
  clk_state_t out_st_r;
  logic       out_new_day_r;
  logic       adv;
  item_t      in_item;

  // Step the word in the input register when the output register can take it
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  assign in_item = '{opcode:  opcode_t'(in_opcode),
                     hours:   in_load_hours,
                     minutes: in_load_minutes,
                     seconds: in_load_seconds,
                     day:     in_load_day,
                     month:   in_load_month,
                     year:    in_load_year,
                     weekday: in_load_weekday};

  // Capture the input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_item;
    end
  end

  ccdst_step u_step (
    .cur     (st_r),
    .item    (in_item_r),
    .nxt     (st_nxt),
    .new_day (new_day_nxt)
  );

  // Advance the clock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{hours: 5'd0, minutes: 6'd0, seconds: 6'd0, day: DAY_MIN,
                month: MONTH_MIN, year: YEAR_RESET, weekday: WEEKDAY_RESET,
                fb_armed: 1'b1};
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_st_r      <= st_nxt;
      out_new_day_r <= new_day_nxt;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_hours   = out_st_r.hours;
  assign out_minutes = out_st_r.minutes;
  assign out_seconds = out_st_r.seconds;
  assign out_day     = out_st_r.day;
  assign out_month   = out_st_r.month;
  assign out_year    = out_st_r.year;
  assign out_weekday = out_st_r.weekday;
  assign out_new_day = out_new_day_r;

  // Internal checks
  `CCDST_ASSERT_SAME(a_time_range, 1'b1, st_r.hours <= HOUR_MAX && st_r.minutes <= MINSEC_MAX && st_r.seconds <= MINSEC_MAX, "clock state out of range")
  `CCDST_ASSERT_SAME(a_stall_cause, in_stall, out_vld_r && out_stall, "input stalled without a stalled output")
  `CCDST_ASSERT_NEXT(a_adv_fills, adv, out_vld_r, "stepped word lost")
  `CCDST_ASSERT_SAME(a_midnight, out_vld_r && out_new_day_r, out_st_r.hours == 5'd0 && out_st_r.minutes == 6'd0 && out_st_r.seconds == 6'd0, "new day away from midnight")
  `CCDST_ASSERT_SAME(a_fall_back, $fell(st_r.fb_armed), st_r.month == MONTH_OCT && st_r.hours == HOUR_SPRING, "fall-back guard cleared outside October switch")

endmodule
